[sv/fbws_pkg.sv]
// ----------------------------------------------------------------------------
// fbws_pkg
// shared types and constants of the frame buffer write sequencer
// ----------------------------------------------------------------------------
package fbws_pkg;

	localparam int unsigned MAX_WIDTH_DEF      = 2048;
	localparam int unsigned MAX_HEIGHT_DEF     = 2048;
	localparam int unsigned MAX_COMPONENTS_DEF = 4;

	localparam int unsigned OFFSET_W = 12;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned ADDR_W   = 22;
	localparam int unsigned COUNT_W  = 32;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [OFFSET_W-1:0] DATA_OFFSET    = 12'h000;
	localparam logic [OFFSET_W-1:0] IGNORED_OFFSET = 12'h880;

	typedef struct packed {
		logic                command;
		logic [OFFSET_W-1:0] offset;
		logic [DATA_W-1:0]   write_data;
	} item_t;

	typedef struct packed {
		logic              bad_offset;
		logic              pixel_write;
		logic              buffer_half;
		logic [ADDR_W-1:0] pixel_address;
		logic [DATA_W-1:0] pixel_data;
		logic              frame_done;
		logic              limit_reached;
		logic              setup_complete;
	} result_t;

endpackage

[sv/fbws_if.sv]
// ----------------------------------------------------------------------------
// fbws interfaces
// valid/ready channels for bus accesses and for results
// ----------------------------------------------------------------------------
interface fbws_in_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [fbws_pkg::OFFSET_W-1:0] offset;
	logic [fbws_pkg::DATA_W-1:0]   write_data;

	modport source (output valid, output command, output offset, output write_data,
		input ready);
	modport sink (input valid, input command, input offset, input write_data,
		output ready);
endinterface

interface fbws_out_if;
	logic                        valid;
	logic                        ready;
	logic                        bad_offset;
	logic                        pixel_write;
	logic                        buffer_half;
	logic [fbws_pkg::ADDR_W-1:0] pixel_address;
	logic [fbws_pkg::DATA_W-1:0] pixel_data;
	logic                        frame_done;
	logic                        limit_reached;
	logic                        setup_complete;

	modport source (output valid, output bad_offset, output pixel_write,
		output buffer_half, output pixel_address, output pixel_data,
		output frame_done, output limit_reached, output setup_complete, input ready);
	modport sink (input valid, input bad_offset, input pixel_write,
		input buffer_half, input pixel_address, input pixel_data,
		input frame_done, input limit_reached, input setup_complete, output ready);
	modport mon (input valid, input bad_offset, input pixel_write,
		input buffer_half, input pixel_address, input pixel_data,
		input frame_done, input limit_reached, input setup_complete, input ready);
endinterface

[sv/fbws_seq.sv]
// ----------------------------------------------------------------------------
// fbws_seq
// setup registers, column/row counters, running row base and frame state;
// forms the result of one access and advances the state when stepped
// ----------------------------------------------------------------------------
module fbws_seq #(
	parameter int unsigned MAX_WIDTH      = fbws_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT     = fbws_pkg::MAX_HEIGHT_DEF,
	parameter int unsigned MAX_COMPONENTS = fbws_pkg::MAX_COMPONENTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  fbws_pkg::item_t              item,
	input  logic [fbws_pkg::COUNT_W-1:0] frame_limit,
	output fbws_pkg::result_t            result
);

	localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned CW   = $clog2(MAX_COMPONENTS + 1);
	localparam int unsigned RW_W = $clog2((MAX_WIDTH / 4) * MAX_COMPONENTS + 1);
	localparam int unsigned AW   = fbws_pkg::ADDR_W;
	localparam int unsigned DW   = fbws_pkg::DATA_W;
	localparam int unsigned NW   = fbws_pkg::COUNT_W;

	logic [WW-1:0]   width_q, width_d;
	logic [HW-1:0]   height_q, height_d;
	logic [CW-1:0]   comp_q, comp_d;
	logic            ready_q, ready_d;
	logic [RW_W-1:0] row_words_q, row_words_d;
	logic [RW_W-1:0] col_q, col_d;
	logic [HW-1:0]   row_q, row_d;
	logic [AW-1:0]   row_base_q, row_base_d;
	logic            half_q, half_d;
	logic [NW-1:0]   frame_q, frame_d;

	logic [WW-1:0]   width_clamp;
	logic [HW-1:0]   height_clamp;
	logic [CW-1:0]   comp_clamp;
	logic [RW_W-1:0] row_len;
	logic [RW_W:0]   col_inc;
	logic [HW:0]     row_inc;
	logic [NW-1:0]   frame_inc;

	assign width_clamp  = (item.write_data > DW'(MAX_WIDTH)) ? WW'(MAX_WIDTH)
		: item.write_data[WW-1:0];
	assign height_clamp = (item.write_data > DW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
		: item.write_data[HW-1:0];
	assign comp_clamp   = (item.write_data > DW'(MAX_COMPONENTS)) ? CW'(MAX_COMPONENTS)
		: item.write_data[CW-1:0];
	assign row_len      = RW_W'(width_q >> 2) * RW_W'(comp_clamp);
	assign col_inc      = {1'b0, col_q} + (RW_W+1)'(1);
	assign row_inc      = {1'b0, row_q} + (HW+1)'(1);
	assign frame_inc    = frame_q + NW'(1);

	always_comb begin
		width_d     = width_q;
		height_d    = height_q;
		comp_d      = comp_q;
		ready_d     = ready_q;
		row_words_d = row_words_q;
		col_d       = col_q;
		row_d       = row_q;
		row_base_d  = row_base_q;
		half_d      = half_q;
		frame_d     = frame_q;

		result                = '0;
		result.buffer_half    = half_q;

		if (item.command == fbws_pkg::CMD_WRITE) begin
			if (item.offset == fbws_pkg::DATA_OFFSET) begin
				if (!ready_q) begin
					if (width_q == '0) begin
						width_d = width_clamp;
					end else if (height_q == '0) begin
						height_d = height_clamp;
					end else begin
						comp_d      = comp_clamp;
						row_words_d = (row_len == '0) ? RW_W'(1) : row_len;
						col_d       = '0;
						row_d       = '0;
						row_base_d  = '0;
						ready_d     = 1'b1;
					end
				end else begin
					result.pixel_write   = 1'b1;
					result.pixel_address = row_base_q + AW'(col_q);
					result.pixel_data    = item.write_data;
					col_d = col_inc[RW_W-1:0];
					if (col_inc >= {1'b0, row_words_q}) begin
						col_d      = '0;
						row_d      = row_inc[HW-1:0];
						row_base_d = row_base_q + AW'(row_words_q);
						if (row_inc >= {1'b0, height_q}) begin
							row_d             = '0;
							row_base_d        = '0;
							frame_d           = frame_inc;
							half_d            = ~half_q;
							result.frame_done = 1'b1;
							result.limit_reached = (frame_limit != '0)
								&& (frame_inc == frame_limit);
						end
					end
				end
			end else if (item.offset != fbws_pkg::IGNORED_OFFSET) begin
				result.bad_offset = 1'b1;
			end
		end
		result.setup_complete = ready_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= '0;
			height_q    <= '0;
			comp_q      <= '0;
			ready_q     <= 1'b0;
			row_words_q <= '0;
			col_q       <= '0;
			row_q       <= '0;
			row_base_q  <= '0;
			half_q      <= 1'b0;
			frame_q     <= '0;
		end else if (step) begin
			width_q     <= width_d;
			height_q    <= height_d;
			comp_q      <= comp_d;
			ready_q     <= ready_d;
			row_words_q <= row_words_d;
			col_q       <= col_d;
			row_q       <= row_d;
			row_base_q  <= row_base_d;
			half_q      <= half_d;
			frame_q     <= frame_d;
		end
	end

endmodule

[sv/framebuffer_write_sequencer_top.sv]
// ----------------------------------------------------------------------------
// framebuffer_write_sequencer_top
// bus slave that loads image setup and sequences pixel word writes into a
// double-buffered frame store
// ----------------------------------------------------------------------------
//  channel   modport  role
//  bus       sink     bus accesses (command, offset, write_data)
//  result    source   one result per access
//  cfg_wr_*  -        frame_limit register write
//
// one transfer per cycle sustained while result.ready holds; an access enters the
// input register at its transfer, moves on to the result register and leaves
// from there as a result transfer
// state advances when an access moves from the input register to the result
// register, so stalls on result hold everything in place
// reset clears setup, counters, frame state, frame_limit and both valid bits
module framebuffer_write_sequencer_top #(
	parameter int unsigned MAX_WIDTH      = fbws_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT     = fbws_pkg::MAX_HEIGHT_DEF,
	parameter int unsigned MAX_COMPONENTS = fbws_pkg::MAX_COMPONENTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [fbws_pkg::COUNT_W-1:0] cfg_wr_data,
	fbws_in_if.sink                      bus,
	fbws_out_if.source                   result
);

	logic [fbws_pkg::COUNT_W-1:0] frame_limit_q;
	logic                         valid_s1, valid_s2;
	fbws_pkg::item_t              item_s1;
	fbws_pkg::result_t            res_s2;
	fbws_pkg::result_t            res_comb;
	logic                         adv_s1;

	assign adv_s1    = valid_s1 && (!valid_s2 || result.ready);
	assign bus.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q <= '0;
		end else if (cfg_wr_en) begin
			frame_limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (bus.ready) begin
				valid_s1 <= bus.valid;
			end
			if (!valid_s2 || result.ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bus.valid && bus.ready) begin
			item_s1.command    <= bus.command;
			item_s1.offset     <= bus.offset;
			item_s1.write_data <= bus.write_data;
		end
		if (adv_s1) begin
			res_s2 <= res_comb;
		end
	end

	fbws_seq #(
		.MAX_WIDTH      (MAX_WIDTH),
		.MAX_HEIGHT     (MAX_HEIGHT),
		.MAX_COMPONENTS (MAX_COMPONENTS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv_s1),
		.item        (item_s1),
		.frame_limit (frame_limit_q),
		.result      (res_comb)
	);

	assign result.valid          = valid_s2;
	assign result.bad_offset     = res_s2.bad_offset;
	assign result.pixel_write    = res_s2.pixel_write;
	assign result.buffer_half    = res_s2.buffer_half;
	assign result.pixel_address  = res_s2.pixel_address;
	assign result.pixel_data     = res_s2.pixel_data;
	assign result.frame_done     = res_s2.frame_done;
	assign result.limit_reached  = res_s2.limit_reached;
	assign result.setup_complete = res_s2.setup_complete;

endmodule

[sv/fbws_checker.sv]
// ----------------------------------------------------------------------------
// fbws_checker
// port-level checks on the result channel of the write sequencer
// ----------------------------------------------------------------------------
module fbws_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic bad_offset,
	input logic pixel_write,
	input logic frame_done,
	input logic limit_reached,
	input logic setup_complete
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	a_pixel_needs_setup: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && pixel_write |-> setup_complete)
		else $error("pixel stored before setup complete");

	a_done_needs_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_done |-> pixel_write)
		else $error("frame done without pixel transfer");

	a_limit_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && limit_reached |-> frame_done)
		else $error("limit reached without frame done");

	a_bad_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && bad_offset |-> !pixel_write && !frame_done)
		else $error("bad offset with pixel activity");

endmodule

bind framebuffer_write_sequencer_top fbws_checker u_fbws_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.bad_offset     (result.bad_offset),
	.pixel_write    (result.pixel_write),
	.frame_done     (result.frame_done),
	.limit_reached  (result.limit_reached),
	.setup_complete (result.setup_complete)
);
